FILE: hw/rtl/bezier_path_flattener_macros.svh
// assertion macros for the bezier path flattener
// no dependencies; taken in by the files that carry assertions
`ifndef BEZIER_PATH_FLATTENER_MACROS_SVH
`define BEZIER_PATH_FLATTENER_MACROS_SVH
`ifndef SYNTHESIS
`define BPF_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("bpf assertion failed");
`define BPF_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("bpf assertion failed");
`else
`define BPF_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define BPF_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: hw/rtl/bpf_pkg.sv
// shared types and constants of the bezier path flattener
// no dependencies; used by every rtl module of the block
package bpf_pkg;

	localparam int SEG_W  = 6;
	localparam int DEN_W  = 18;
	localparam int SUM_W  = 23;
	localparam int RAD_W  = 42;

	localparam logic [2:0] CMD_MOVE  = 3'd0;
	localparam logic [2:0] CMD_LINE  = 3'd1;
	localparam logic [2:0] CMD_QUAD  = 3'd2;
	localparam logic [2:0] CMD_CUBIC = 3'd3;
	localparam logic [2:0] CMD_CLOSE = 3'd4;

	localparam logic [1:0] OP_MOVE  = 2'd0;
	localparam logic [1:0] OP_LINE  = 2'd1;
	localparam logic [1:0] OP_CLOSE = 2'd2;

	localparam logic REG_MIN_SEG = 1'b0;
	localparam logic REG_MAX_SEG = 1'b1;

	localparam logic [SEG_W-1:0] MIN_SEG_RST = 6'd4;
	localparam logic [SEG_W-1:0] MAX_SEG_RST = 6'd63;

	localparam logic [SUM_W-1:0] LEG_SAT    = 23'h100000;
	localparam logic [SUM_W-1:0] ROUND_HALF = 23'd512;
	localparam logic [RAD_W-1:0] ROOT_BIT0  = {2'b01, 40'b0};
	localparam logic [4:0]       ROOT_STEPS = 5'd20;

	typedef struct packed {
		logic [SEG_W-1:0] min_seg;
		logic [SEG_W-1:0] max_seg;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

FILE: hw/rtl/bpf_front.sv
// front end: accepts path commands, keeps pen and subpath start, builds queue entries
// depends on bpf_pkg
module bpf_front #(
	parameter int CB = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [2:0]            cmd,
	input  logic signed [CB-1:0]  p0_x,
	input  logic signed [CB-1:0]  p0_y,
	input  logic signed [CB-1:0]  p1_x,
	input  logic signed [CB-1:0]  p1_y,
	input  logic signed [CB-1:0]  p2_x,
	input  logic signed [CB-1:0]  p2_y,
	input  bpf_pkg::fifo_stat_t   qstat,
	output logic                  push,
	output logic [3+8*CB-1:0]     entry
);

	logic [CB-1:0] last_x_q, last_y_q, start_x_q, start_y_q;
	logic [CB-1:0] pt0_x, pt0_y;
	logic          acc, curve;

	assign in_ready = !qstat.full;
	assign acc      = in_valid && in_ready;
	assign push     = acc && (cmd <= bpf_pkg::CMD_CLOSE);
	assign curve    = (cmd == bpf_pkg::CMD_QUAD) || (cmd == bpf_pkg::CMD_CUBIC);

	always_comb begin
		if (curve) begin
			pt0_x = last_x_q;
			pt0_y = last_y_q;
		end else if (cmd == bpf_pkg::CMD_CLOSE) begin
			pt0_x = start_x_q;
			pt0_y = start_y_q;
		end else begin
			pt0_x = p0_x;
			pt0_y = p0_y;
		end
	end

	assign entry = {cmd, pt0_x, pt0_y, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q  <= '0;
			last_y_q  <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (acc) begin
			case (cmd)
				bpf_pkg::CMD_MOVE: begin
					last_x_q  <= p0_x;
					last_y_q  <= p0_y;
					start_x_q <= p0_x;
					start_y_q <= p0_y;
				end
				bpf_pkg::CMD_LINE: begin
					last_x_q <= p0_x;
					last_y_q <= p0_y;
				end
				bpf_pkg::CMD_QUAD: begin
					last_x_q <= p1_x;
					last_y_q <= p1_y;
				end
				bpf_pkg::CMD_CUBIC: begin
					last_x_q <= p2_x;
					last_y_q <= p2_y;
				end
				bpf_pkg::CMD_CLOSE: begin
					last_x_q <= start_x_q;
					last_y_q <= start_y_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/bpf_fifo.sv
// two-entry command queue between front and back end
// depends on bpf_pkg
module bpf_fifo #(
	parameter int W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        wdata,
	input  logic                pop,
	output logic [W-1:0]        rdata,
	output bpf_pkg::fifo_stat_t stat
);

	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign rdata      = mem_q[rp_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

FILE: hw/rtl/bpf_div.sv
// bit-serial floor divider of a signed numerator by an unsigned denominator
// depends on bpf_pkg
module bpf_div #(
	parameter int NW = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [NW-1:0]      num,
	input  logic [bpf_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [NW-1:0]             quo,
	output logic [bpf_pkg::DEN_W-1:0] rem
);

	localparam int DW = bpf_pkg::DEN_W;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] a_q;
	logic [DW-1:0] rem_q, den_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q, busy_q, done_q;
	logic [DW:0]   rsh, rdif;
	logic          ge, rz;

	assign rsh  = {rem_q, a_q[NW-1]};
	assign rdif = rsh - {1'b0, den_q};
	assign ge   = (rsh >= {1'b0, den_q});
	assign rz   = (rem_q == '0);
	assign done = done_q;
	assign quo  = !neg_q ? a_q : (rz ? -a_q : ~a_q);
	assign rem  = (!neg_q || rz) ? rem_q : den_q - rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= num[NW-1] ? -num : num;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[NW-1];
		end else if (busy_q) begin
			rem_q <= ge ? rdif[DW-1:0] : rsh[DW-1:0];
			a_q   <= {a_q[NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/bpf_back.sv
// back end: segment count, curve set-up and forward-differenced point output
// depends on bpf_pkg and bpf_div
module bpf_back #(
	parameter int CB     = 24,
	parameter int MAXSEG = 63
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpf_pkg::fifo_stat_t   qstat,
	input  logic [3+8*CB-1:0]     entry,
	output logic                  pop,
	input  bpf_pkg::cfg_t         cfg,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            op,
	output logic signed [CB-1:0]  out_x,
	output logic signed [CB-1:0]  out_y,
	output logic                  last
);

	localparam int CW   = CB + 4;
	localparam int NW   = CB + 24;
	localparam int QW   = CB + 6;
	localparam int DW   = (CB + 1 > 21) ? CB + 1 : 21;
	localparam int EW   = 3 + 8 * CB;
	localparam int DENW = bpf_pkg::DEN_W;
	localparam int SW   = bpf_pkg::SEG_W;
	localparam int RW   = bpf_pkg::RAD_W;
	localparam int UW   = bpf_pkg::SUM_W;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_SIMP  = 4'd1;
	localparam logic [3:0] ST_CLS   = 4'd2;
	localparam logic [3:0] ST_SQX   = 4'd3;
	localparam logic [3:0] ST_SQY   = 4'd4;
	localparam logic [3:0] ST_ROOT  = 4'd5;
	localparam logic [3:0] ST_SEG   = 4'd6;
	localparam logic [3:0] ST_MUL   = 4'd7;
	localparam logic [3:0] ST_DIV   = 4'd8;
	localparam logic [3:0] ST_FIRST = 4'd9;
	localparam logic [3:0] ST_INT   = 4'd10;
	localparam logic [3:0] ST_END   = 4'd11;

	function automatic logic [QW+DENW-1:0] madd(input logic [QW-1:0] qa,
		input logic [DENW-1:0] ra, input logic [QW-1:0] qb,
		input logic [DENW-1:0] rb, input logic [DENW-1:0] d);
		logic [DENW:0] rs;
		logic [DENW:0] rd;
		logic [QW-1:0] q;
		rs = {1'b0, ra} + {1'b0, rb};
		rd = rs - {1'b0, d};
		q  = qa + qb;
		if (rs >= {1'b0, d}) begin
			madd = {q + QW'(1), rd[DENW-1:0]};
		end else begin
			madd = {q, rs[DENW-1:0]};
		end
	endfunction

	function automatic logic [3*CW-1:0] coef(input logic cub, input logic [CB-1:0] a0,
		input logic [CB-1:0] a1, input logic [CB-1:0] a2, input logic [CB-1:0] a3);
		logic signed [CW-1:0] e0, e1, e2, e3, d10, s, t, c1, c2, c3;
		e0  = CW'($signed(a0));
		e1  = CW'($signed(a1));
		e2  = CW'($signed(a2));
		e3  = CW'($signed(a3));
		d10 = e1 - e0;
		s   = e0 - (e1 <<< 1) + e2;
		t   = e1 - e2;
		c1  = cub ? (d10 <<< 1) + d10 : (d10 <<< 1);
		c2  = cub ? (s <<< 1) + s : s;
		c3  = cub ? e3 - e0 + (t <<< 1) + t : '0;
		coef = {c1, c2, c3};
	endfunction

	logic [3:0]     state_q;
	logic [2:0]     kind_q;
	logic [CB-1:0]  ptx_q [4];
	logic [CB-1:0]  pty_q [4];
	logic [CB-1:0]  lgx_q [4];
	logic [CB-1:0]  lgy_q [4];
	logic [1:0]     leg_q;
	logic [39:0]    sqx_q;
	logic [19:0]    dya_q;
	logic           sat_q;
	logic [RW-1:0]  rad_q, root_q, bit_q;
	logic [4:0]     rcnt_q;
	logic [UW-1:0]  sum_q;
	logic [SW-1:0]  n_q, k_q;
	logic [11:0]    n2_q;
	logic [DENW-1:0] n3_q;
	logic [2:0]     mstep_q;
	logic signed [NW-1:0] ta_q [2];
	logic signed [NW-1:0] tb_q [2];
	logic [2:0]     didx_q;
	logic           dgo_q;
	logic [QW-1:0]  vq_q  [2];
	logic [DENW-1:0] vr_q [2];
	logic [QW-1:0]  dq_q  [2][3];
	logic [DENW-1:0] dr_q [2][3];
	logic           ov_q, last_q;
	logic [1:0]     op_q;
	logic [CB-1:0]  ox_q, oy_q;

	logic           cub, ofree, emit, e_last;
	logic [1:0]     e_op;
	logic [CB-1:0]  e_x, e_y;
	logic [3*CW-1:0] cfx, cfy;
	logic signed [CW-1:0] c1x, c2x, c3x, c1y, c2y, c3y;
	logic signed [DW-1:0] dxs, dys;
	logic [DW-1:0]  dxa, dya;
	logic           sat;
	logic [RW-1:0]  rtry, root_nx;
	logic           rge;
	logic [12:0]    nraw;
	logic [12:0]    nsel;
	logic signed [CW-1:0] mul_a;
	logic [DENW-1:0] mul_b;
	logic signed [NW-1:0] mul_p;
	logic [DENW-1:0] den;
	logic signed [NW-1:0] c3wx, c3wy, six_c3x, six_c3y, dnum;
	logic           dstart, ddone;
	logic [NW-1:0]  dquo;
	logic [DENW-1:0] drem;
	logic [QW+DENW-1:0] sv [2];
	logic [QW+DENW-1:0] s1 [2];
	logic [QW+DENW-1:0] s2 [2];
	logic [QW-1:0]  rnd [2];

	assign cub   = (kind_q == bpf_pkg::CMD_CUBIC);
	assign ofree = !ov_q || out_ready;
	assign pop   = (state_q == ST_IDLE) && !qstat.empty;

	assign cfx = coef(cub, ptx_q[0], ptx_q[1], ptx_q[2], ptx_q[3]);
	assign cfy = coef(cub, pty_q[0], pty_q[1], pty_q[2], pty_q[3]);
	assign {c1x, c2x, c3x} = cfx;
	assign {c1y, c2y, c3y} = cfy;

	// control-polygon leg, always between the two lowest shift slots
	assign dxs = DW'($signed(lgx_q[1])) - DW'($signed(lgx_q[0]));
	assign dys = DW'($signed(lgy_q[1])) - DW'($signed(lgy_q[0]));
	assign dxa = dxs[DW-1] ? -dxs : dxs;
	assign dya = dys[DW-1] ? -dys : dys;
	assign sat = (|dxa[DW-1:20]) || (|dya[DW-1:20]);

	assign rtry    = root_q + bit_q;
	assign rge     = (rad_q >= rtry);
	assign root_nx = rge ? (root_q >> 1) + bit_q : (root_q >> 1);

	always_comb begin
		nraw = 13'((sum_q + bpf_pkg::ROUND_HALF) >> 10);
		nsel = nraw;
		if (nsel < 13'(cfg.min_seg)) begin
			nsel = 13'(cfg.min_seg);
		end
		if (nsel > 13'(cfg.max_seg)) begin
			nsel = 13'(cfg.max_seg);
		end
		if (nsel > 13'(MAXSEG)) begin
			nsel = 13'(MAXSEG);
		end
		if (nsel == 13'd0) begin
			nsel = 13'd1;
		end
	end

	// one shared multiplier for the set-up products
	always_comb begin
		case (mstep_q)
			3'd0: begin
				mul_a = CW'(n_q);
				mul_b = DENW'(n_q);
			end
			3'd1: begin
				mul_a = CW'(n2_q);
				mul_b = DENW'(n_q);
			end
			3'd2: begin
				mul_a = c1x;
				mul_b = cub ? DENW'(n2_q) : DENW'(n_q);
			end
			3'd3: begin
				mul_a = c2x;
				mul_b = cub ? DENW'(n_q) : DENW'(1);
			end
			3'd4: begin
				mul_a = c1y;
				mul_b = cub ? DENW'(n2_q) : DENW'(n_q);
			end
			default: begin
				mul_a = c2y;
				mul_b = cub ? DENW'(n_q) : DENW'(1);
			end
		endcase
	end

	assign mul_p = NW'($signed({{(NW-CW){mul_a[CW-1]}}, mul_a})
		* $signed({{(NW-DENW){1'b0}}, mul_b}));

	assign den     = cub ? n3_q : DENW'(n2_q);
	assign c3wx    = NW'(c3x);
	assign c3wy    = NW'(c3y);
	assign six_c3x = (c3wx <<< 2) + (c3wx <<< 1);
	assign six_c3y = (c3wy <<< 2) + (c3wy <<< 1);

	always_comb begin
		case (didx_q)
			3'd0:    dnum = ta_q[0] + tb_q[0] + c3wx;
			3'd1:    dnum = (tb_q[0] <<< 1) + six_c3x;
			3'd2:    dnum = six_c3x;
			3'd3:    dnum = ta_q[1] + tb_q[1] + c3wy;
			3'd4:    dnum = (tb_q[1] <<< 1) + six_c3y;
			default: dnum = six_c3y;
		endcase
	end

	assign dstart = (state_q == ST_DIV) && !dgo_q;

	bpf_div #(.NW(NW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dstart),
		.num    (dnum),
		.den    (den),
		.done   (ddone),
		.quo    (dquo),
		.rem    (drem)
	);

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			sv[a]  = madd(vq_q[a], vr_q[a], dq_q[a][0], dr_q[a][0], den);
			s1[a]  = madd(dq_q[a][0], dr_q[a][0], dq_q[a][1], dr_q[a][1], den);
			s2[a]  = madd(dq_q[a][1], dr_q[a][1], dq_q[a][2], dr_q[a][2], den);
			rnd[a] = sv[a][QW+DENW-1:DENW]
				+ QW'({sv[a][DENW-1:0], 1'b0} >= {1'b0, den});
		end
	end

	always_comb begin
		emit   = 1'b0;
		e_op   = bpf_pkg::OP_LINE;
		e_x    = '0;
		e_y    = '0;
		e_last = 1'b0;
		case (state_q)
			ST_SIMP: begin
				emit = ofree;
				e_x  = ptx_q[0];
				e_y  = pty_q[0];
				if (kind_q == bpf_pkg::CMD_MOVE) begin
					e_op   = bpf_pkg::OP_MOVE;
					e_last = 1'b1;
				end else if (kind_q == bpf_pkg::CMD_LINE) begin
					e_last = 1'b1;
				end
			end
			ST_CLS: begin
				emit   = ofree;
				e_op   = bpf_pkg::OP_CLOSE;
				e_last = 1'b1;
			end
			ST_FIRST: begin
				emit = ofree;
				e_x  = ptx_q[0];
				e_y  = pty_q[0];
			end
			ST_INT: begin
				emit = ofree;
				e_x  = rnd[0][CB-1:0];
				e_y  = rnd[1][CB-1:0];
			end
			ST_END: begin
				emit   = ofree;
				e_x    = cub ? ptx_q[3] : ptx_q[2];
				e_y    = cub ? pty_q[3] : pty_q[2];
				e_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= entry[EW-1 -: 3];
			for (int i = 0; i < 4; i++) begin
				ptx_q[i] <= entry[(7-2*i)*CB +: CB];
				pty_q[i] <= entry[(6-2*i)*CB +: CB];
				lgx_q[i] <= entry[(7-2*i)*CB +: CB];
				lgy_q[i] <= entry[(6-2*i)*CB +: CB];
			end
			sum_q <= '0;
		end
		if (emit) begin
			op_q   <= e_op;
			ox_q   <= e_x;
			oy_q   <= e_y;
			last_q <= e_last;
		end
		case (state_q)
			ST_SQX: begin
				sqx_q <= 40'(dxa[19:0] * dxa[19:0]);
				dya_q <= dya[19:0];
				sat_q <= sat;
			end
			ST_SQY: begin
				rad_q  <= RW'(sqx_q) + RW'(dya_q * dya_q);
				root_q <= '0;
				bit_q  <= bpf_pkg::ROOT_BIT0;
				rcnt_q <= bpf_pkg::ROOT_STEPS;
				if (sat_q) begin
					sum_q <= sum_q + bpf_pkg::LEG_SAT;
					for (int i = 0; i < 3; i++) begin
						lgx_q[i] <= lgx_q[i+1];
						lgy_q[i] <= lgy_q[i+1];
					end
				end
			end
			ST_ROOT: begin
				if (rge) begin
					rad_q <= rad_q - rtry;
				end
				root_q <= root_nx;
				bit_q  <= bit_q >> 2;
				rcnt_q <= rcnt_q - 5'd1;
				if (rcnt_q == 5'd0) begin
					sum_q <= sum_q + root_nx[UW-1:0];
					for (int i = 0; i < 3; i++) begin
						lgx_q[i] <= lgx_q[i+1];
						lgy_q[i] <= lgy_q[i+1];
					end
				end
			end
			ST_SEG: begin
				n_q <= nsel[SW-1:0];
			end
			ST_MUL: begin
				case (mstep_q)
					3'd0:    n2_q     <= mul_p[11:0];
					3'd1:    n3_q     <= mul_p[DENW-1:0];
					3'd2:    ta_q[0]  <= mul_p;
					3'd3:    tb_q[0]  <= mul_p;
					3'd4:    ta_q[1]  <= mul_p;
					default: tb_q[1]  <= mul_p;
				endcase
			end
			ST_DIV: begin
				if (ddone) begin
					case (didx_q)
						3'd0: begin
							dq_q[0][0] <= dquo[QW-1:0];
							dr_q[0][0] <= drem;
						end
						3'd1: begin
							dq_q[0][1] <= dquo[QW-1:0];
							dr_q[0][1] <= drem;
						end
						3'd2: begin
							dq_q[0][2] <= dquo[QW-1:0];
							dr_q[0][2] <= drem;
						end
						3'd3: begin
							dq_q[1][0] <= dquo[QW-1:0];
							dr_q[1][0] <= drem;
						end
						3'd4: begin
							dq_q[1][1] <= dquo[QW-1:0];
							dr_q[1][1] <= drem;
						end
						default: begin
							dq_q[1][2] <= dquo[QW-1:0];
							dr_q[1][2] <= drem;
						end
					endcase
					vq_q[0] <= QW'($signed(ptx_q[0]));
					vq_q[1] <= QW'($signed(pty_q[0]));
					vr_q[0] <= '0;
					vr_q[1] <= '0;
				end
			end
			ST_INT: begin
				if (ofree) begin
					for (int a = 0; a < 2; a++) begin
						{vq_q[a], vr_q[a]}             <= sv[a];
						{dq_q[a][0], dr_q[a][0]}       <= s1[a];
						{dq_q[a][1], dr_q[a][1]}       <= s2[a];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
			leg_q   <= '0;
			mstep_q <= '0;
			didx_q  <= '0;
			dgo_q   <= 1'b0;
			k_q     <= '0;
		end else begin
			if (emit) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						leg_q <= '0;
						if ((entry[EW-1 -: 3] == bpf_pkg::CMD_QUAD)
							|| (entry[EW-1 -: 3] == bpf_pkg::CMD_CUBIC)) begin
							state_q <= ST_SQX;
						end else begin
							state_q <= ST_SIMP;
						end
					end
				end
				ST_SIMP: begin
					if (ofree) begin
						state_q <= (kind_q == bpf_pkg::CMD_CLOSE) ? ST_CLS : ST_IDLE;
					end
				end
				ST_CLS: begin
					if (ofree) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: begin
					if (!sat_q) begin
						state_q <= ST_ROOT;
					end else if (leg_q == (cub ? 2'd2 : 2'd1)) begin
						state_q <= ST_SEG;
					end else begin
						leg_q   <= leg_q + 2'd1;
						state_q <= ST_SQX;
					end
				end
				ST_ROOT: begin
					if (rcnt_q == 5'd0) begin
						if (leg_q == (cub ? 2'd2 : 2'd1)) begin
							state_q <= ST_SEG;
						end else begin
							leg_q   <= leg_q + 2'd1;
							state_q <= ST_SQX;
						end
					end
				end
				ST_SEG: begin
					mstep_q <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd5) begin
						didx_q  <= '0;
						dgo_q   <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dstart) begin
						dgo_q <= 1'b1;
					end
					if (ddone) begin
						dgo_q  <= 1'b0;
						didx_q <= didx_q + 3'd1;
						if (didx_q == 3'd5) begin
							state_q <= ST_FIRST;
						end
					end
				end
				ST_FIRST: begin
					if (ofree) begin
						k_q     <= SW'(1);
						state_q <= (n_q == SW'(1)) ? ST_END : ST_INT;
					end
				end
				ST_INT: begin
					if (ofree) begin
						k_q <= k_q + SW'(1);
						if (k_q == n_q - SW'(1)) begin
							state_q <= ST_END;
						end
					end
				end
				ST_END: begin
					if (ofree) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = ov_q;
	assign op        = op_q;
	assign out_x     = ox_q;
	assign out_y     = oy_q;
	assign last      = last_q;

endmodule

FILE: hw/rtl/bezier_path_flattener.sv
// Bezier path flattener: path commands in, polyline items out. Move and line give
// one item, close two. A curve goes through a single iterative back end: per
// control-polygon leg a square step for each axis and, unless it saturates, 21 root
// steps; six products on one shared multiplier; six floor divisions (start, bit steps
// and finish) on one bit-serial divider; then one output point per cycle while the
// output is not stalled (n+1 points). A two-entry queue lets the front take commands
// while the back works; an output register holds each item.
// depends on bpf_pkg, bpf_front, bpf_fifo, bpf_div, bpf_back and the macro header
`include "bezier_path_flattener_macros.svh"
module bezier_path_flattener #(
	parameter int COORD_BITS   = 24,
	parameter int MAX_SEGMENTS = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   cmd,
	input  logic signed [COORD_BITS-1:0] p0_x,
	input  logic signed [COORD_BITS-1:0] p0_y,
	input  logic signed [COORD_BITS-1:0] p1_x,
	input  logic signed [COORD_BITS-1:0] p1_y,
	input  logic signed [COORD_BITS-1:0] p2_x,
	input  logic signed [COORD_BITS-1:0] p2_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   op,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         last,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	localparam int EW = 3 + 8 * COORD_BITS;

	bpf_pkg::cfg_t       cfg_q;
	bpf_pkg::fifo_stat_t qstat;
	logic [EW-1:0]       f_entry, b_entry;
	logic                push, pop, wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign prdata = (paddr[2] == bpf_pkg::REG_MAX_SEG) ? 32'(cfg_q.max_seg)
		: 32'(cfg_q.min_seg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_seg <= bpf_pkg::MIN_SEG_RST;
			cfg_q.max_seg <= bpf_pkg::MAX_SEG_RST;
		end else if (wr) begin
			if (paddr[2] == bpf_pkg::REG_MIN_SEG) begin
				cfg_q.min_seg <= pwdata[5:0];
			end else begin
				cfg_q.max_seg <= pwdata[5:0];
			end
		end
	end

	bpf_front #(.CB(COORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.p0_x     (p0_x),
		.p0_y     (p0_y),
		.p1_x     (p1_x),
		.p1_y     (p1_y),
		.p2_x     (p2_x),
		.p2_y     (p2_y),
		.qstat    (qstat),
		.push     (push),
		.entry    (f_entry)
	);

	bpf_fifo #(.W(EW)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_entry),
		.pop    (pop),
		.rdata  (b_entry),
		.stat   (qstat)
	);

	bpf_back #(.CB(COORD_BITS), .MAXSEG(MAX_SEGMENTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.entry     (b_entry),
		.pop       (pop),
		.cfg       (cfg_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.op        (op),
		.out_x     (out_x),
		.out_y     (out_y),
		.last      (last)
	);

	`BPF_ASSERT_IMP(a_close_zero, clk, arst_n, out_valid && (op == bpf_pkg::OP_CLOSE), (out_x == '0) && (out_y == '0) && last)
	`BPF_ASSERT_IMP(a_move_last, clk, arst_n, out_valid && (op == bpf_pkg::OP_MOVE), last)
	`BPF_ASSERT_IMP(a_queue_sane, clk, arst_n, 1'b1, !(qstat.full && qstat.empty) && !(pop && qstat.empty))
	`BPF_ASSERT_NXT(a_cfg_min, clk, arst_n, wr && (paddr[2] == bpf_pkg::REG_MIN_SEG), cfg_q.min_seg == $past(pwdata[5:0]))

endmodule

FILE: tb/bpf_checker.sv
// checker for the bezier path flattener: predicts the polyline items from the commands
// accepted on the input channel and compares them with the output channel
// depends on bpf_pkg
module bpf_checker #(
	parameter int COORD_BITS   = 24,
	parameter int MAX_SEGMENTS = 63
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic [2:0]                   cmd,
	input  logic signed [COORD_BITS-1:0] p0_x,
	input  logic signed [COORD_BITS-1:0] p0_y,
	input  logic signed [COORD_BITS-1:0] p1_x,
	input  logic signed [COORD_BITS-1:0] p1_y,
	input  logic signed [COORD_BITS-1:0] p2_x,
	input  logic signed [COORD_BITS-1:0] p2_y,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [1:0]                   op,
	input  logic signed [COORD_BITS-1:0] out_x,
	input  logic signed [COORD_BITS-1:0] out_y,
	input  logic                         last,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output int                           fail_count,
	output int                           pending
);

	typedef struct {
		logic [1:0]            op;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  last;
	} vertex_t;

	vertex_t polyline_q[$];
	logic [bpf_pkg::SEG_W-1:0] min_seg, max_seg;
	longint pen_x, pen_y, sub_x, sub_y;

	assign pending = polyline_q.size();

	function automatic longint isqrt(longint v);
		longint r, b;
		r = 0;
		b = longint'(1) <<< 62;
		while (b > v) b = b >>> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint leg(longint ax, longint ay, longint bx, longint by);
		longint dx, dy;
		dx = bx - ax;
		dy = by - ay;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		if (dx >= 1048576 || dy >= 1048576) return 1048576;
		return isqrt(dx * dx + dy * dy);
	endfunction

	function automatic longint nearest(longint num, longint den);
		longint a, b;
		a = 2 * num + den;
		b = 2 * den;
		if (a >= 0) return a / b;
		return -((-a + b - 1) / b);
	endfunction

	function automatic void push_vertex(logic [1:0] o, longint x, longint y);
		vertex_t v;
		v.op = o;
		v.x = x[COORD_BITS-1:0];
		v.y = y[COORD_BITS-1:0];
		v.last = 1'b0;
		polyline_q.push_back(v);
	endfunction

	function automatic void flatten_curve(bit cubic, longint px[4], longint py[4]);
		longint total, n, den, a, w0, w1, w2, w3, vx, vy;
		int e;
		e = cubic ? 3 : 2;
		total = leg(px[0], py[0], px[1], py[1]) + leg(px[1], py[1], px[2], py[2]);
		if (cubic) total += leg(px[2], py[2], px[3], py[3]);
		n = (total + 512) >>> 10;
		if (n < min_seg) n = min_seg;
		if (n > max_seg) n = max_seg;
		if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
		if (n < 1) n = 1;
		den = cubic ? n * n * n : n * n;
		push_vertex(bpf_pkg::OP_LINE, px[0], py[0]);
		for (longint k = 1; k < n; k++) begin
			a = n - k;
			if (cubic) begin
				w0 = a * a * a; w1 = 3 * k * a * a; w2 = 3 * k * k * a; w3 = k * k * k;
			end else begin
				w0 = a * a; w1 = 2 * k * a; w2 = k * k; w3 = 0;
			end
			vx = px[0] * w0 + px[1] * w1 + px[2] * w2 + px[3] * w3;
			vy = py[0] * w0 + py[1] * w1 + py[2] * w2 + py[3] * w3;
			push_vertex(bpf_pkg::OP_LINE, nearest(vx, den), nearest(vy, den));
		end
		push_vertex(bpf_pkg::OP_LINE, px[e], py[e]);
		pen_x = px[e];
		pen_y = py[e];
	endfunction

	function automatic void predict_command();
		longint px[4], py[4];
		px = '{pen_x, longint'(p0_x), longint'(p1_x), longint'(p2_x)};
		py = '{pen_y, longint'(p0_y), longint'(p1_y), longint'(p2_y)};
		case (cmd)
			bpf_pkg::CMD_MOVE: begin
				push_vertex(bpf_pkg::OP_MOVE, p0_x, p0_y);
				pen_x = p0_x; pen_y = p0_y; sub_x = p0_x; sub_y = p0_y;
			end
			bpf_pkg::CMD_LINE: begin
				push_vertex(bpf_pkg::OP_LINE, p0_x, p0_y);
				pen_x = p0_x; pen_y = p0_y;
			end
			bpf_pkg::CMD_QUAD: begin
				px[3] = 0; py[3] = 0;
				flatten_curve(1'b0, px, py);
			end
			bpf_pkg::CMD_CUBIC: flatten_curve(1'b1, px, py);
			bpf_pkg::CMD_CLOSE: begin
				push_vertex(bpf_pkg::OP_LINE, sub_x, sub_y);
				push_vertex(bpf_pkg::OP_CLOSE, 0, 0);
				pen_x = sub_x; pen_y = sub_y;
			end
			default: return;
		endcase
		polyline_q[$].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vertex_t v;
		if (!arst_n) begin
			polyline_q.delete();
			min_seg = bpf_pkg::MIN_SEG_RST;
			max_seg = bpf_pkg::MAX_SEG_RST;
			pen_x = 0; pen_y = 0; sub_x = 0; sub_y = 0;
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == bpf_pkg::REG_MIN_SEG) min_seg = pwdata[bpf_pkg::SEG_W-1:0];
				else max_seg = pwdata[bpf_pkg::SEG_W-1:0];
			end
			if (out_valid && out_ready) begin
				if (polyline_q.size() == 0) begin
					$error("unexpected item op=%0d x=%0d y=%0d", op, out_x, out_y);
					fail_count++;
				end else begin
					v = polyline_q.pop_front();
					if (op !== v.op) begin
						$error("op expected %0d actual %0d", v.op, op);
						fail_count++;
					end
					if (out_x !== v.x) begin
						$error("out_x expected %0d actual %0d", $signed(v.x), out_x);
						fail_count++;
					end
					if (out_y !== v.y) begin
						$error("out_y expected %0d actual %0d", $signed(v.y), out_y);
						fail_count++;
					end
					if (last !== v.last) begin
						$error("last expected %0d actual %0d", v.last, last);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) predict_command();
		end
	end

endmodule

FILE: tb/tb_bezier_path_flattener.sv
// stimulus top for the bezier path flattener: directed and random path commands,
// register settings between phases, random idling on both channels, verdict
// depends on bpf_pkg, bpf_checker and the block under test
module tb_bezier_path_flattener;

	localparam int CW = 24;
	localparam int WATCHDOG = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0, in_ready;
	logic [2:0] cmd = bpf_pkg::CMD_MOVE;
	logic signed [CW-1:0] p0_x = '0, p0_y = '0, p1_x = '0, p1_y = '0, p2_x = '0, p2_y = '0;
	logic out_valid, out_ready = 1'b0;
	logic [1:0] op;
	logic signed [CW-1:0] out_x, out_y;
	logic last;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;
	int fail_count, pending, quiet;
	bit hold_off = 1'b0;

	always #5 clk = ~clk;

	bezier_path_flattener DUT (.*);

	bpf_checker chk (.*);

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(CW-1){1'b0}}};
			1: return {1'b0, {(CW-1){1'b1}}};
			2, 3: return CW'($urandom);
			default: return CW'(int'($urandom_range(0, 16000)) - 8000);
		endcase
	endfunction

	task automatic send(logic [2:0] c, logic signed [CW-1:0] a, b, d, e, f, g);
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
				@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		p0_x <= a; p0_y <= b; p1_x <= d; p1_y <= e; p2_x <= f; p2_y <= g;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_rand(logic [2:0] c);
		send(c, rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
			rand_coord());
	endtask

	task automatic write_reg(logic [2:0] addr, logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task automatic setting(int lo, int hi);
		drain();
		write_reg({bpf_pkg::REG_MIN_SEG, 2'b00}, lo);
		write_reg({bpf_pkg::REG_MAX_SEG, 2'b00}, hi);
	endtask

	always @(posedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else if ($urandom_range(0, 15) == 0) out_ready <= 1'b0;
		else if ($urandom_range(0, 3) != 0) out_ready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [2:0] c;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// extremes and every command, including close and curve before any move
		send(bpf_pkg::CMD_CLOSE, '0, '0, '0, '0, '0, '0);
		send_rand(bpf_pkg::CMD_QUAD);
		send(bpf_pkg::CMD_MOVE, {1'b1, 23'd0}, {1'b0, {23{1'b1}}}, '0, '0, '0, '0);
		send(bpf_pkg::CMD_LINE, {1'b0, {23{1'b1}}}, {1'b1, 23'd0}, '0, '0, '0, '0);
		send(bpf_pkg::CMD_CUBIC, 24'sd100, 24'sd200, -24'sd300, 24'sd400, 24'sd0, -24'sd5);
		send(bpf_pkg::CMD_CUBIC, {1'b1, 23'd0}, {1'b0, {23{1'b1}}}, {1'b0, {23{1'b1}}},
			{1'b1, 23'd0}, '1, '0);
		send(bpf_pkg::CMD_QUAD, 24'sd0, 24'sd0, 24'sd0, 24'sd0, '0, '0);
		send(bpf_pkg::CMD_QUAD, 24'sd1, -24'sd1, 24'sd3, 24'sd2, '0, '0);
		send(3'd5, '1, '1, '1, '1, '1, '1);
		send(3'd7, '0, '0, '0, '0, '0, '0);
		send(bpf_pkg::CMD_CLOSE, '1, '1, '1, '1, '1, '1);
		send(bpf_pkg::CMD_MOVE, 24'sd1000, 24'sd1000, '0, '0, '0, '0);
		send(bpf_pkg::CMD_LINE, 24'sd1000000, 24'sd2000, '0, '0, '0, '0);
		send(bpf_pkg::CMD_CLOSE, '0, '0, '0, '0, '0, '0);
		// receiver stalls long while the sender keeps going
		fork
			begin
				hold_off = 1'b1;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				repeat (4) send_rand(bpf_pkg::CMD_CUBIC);
				in_valid <= 1'b0;
			end
		join
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: setting(1, 63);
				1: setting(63, 63);
				2: setting(1, 4);
				3: setting(63, 4);
				default: setting($urandom_range(1, 20), $urandom_range(4, 63));
			endcase
			for (int i = 0; i < 30; i++) begin
				case ($urandom_range(0, 19))
					0: c = bpf_pkg::CMD_MOVE;
					1, 2: c = bpf_pkg::CMD_LINE;
					3, 4, 5, 6, 7, 8: c = bpf_pkg::CMD_QUAD;
					9, 10, 11, 12, 13, 14, 15: c = bpf_pkg::CMD_CUBIC;
					16, 17: c = bpf_pkg::CMD_CLOSE;
					default: c = 3'($urandom_range(0, 7));
				endcase
				send_rand(c);
			end
		end
		drain();
		if (fail_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/bpf_pkg.sv
hw/rtl/bpf_front.sv
hw/rtl/bpf_fifo.sv
hw/rtl/bpf_div.sv
hw/rtl/bpf_back.sv
hw/rtl/bezier_path_flattener.sv
tb/bpf_checker.sv
tb/tb_bezier_path_flattener.sv
